>>> hdl/assert_macros.svh
// Assertion shorthands used by the heap queue checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define HMQ_ASSERT_IMPL(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("heap queue check failed");

// Next-cycle implication, disabled while reset is high.
`define HMQ_ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("heap queue check failed");

`endif

>>> hdl/hmq_pkg.sv
package hmq_pkg;

  localparam int DEF_CAPACITY     = 64;
  localparam int DEF_KEY_BITS     = 32;
  localparam int DEF_PAYLOAD_BITS = 32;

  localparam int FIELD_W     = 32;
  localparam int COUNT_OUT_W = 7;
  localparam int STATUS_W    = 2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } result_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_DN_LAST,
    S_DN_LOAD,
    S_DN_RD,
    S_DN_CMP,
    S_HEAD_RD,
    S_PUBLISH
  } hmq_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_UP_RD,
    OP_UP_CMP,
    OP_DN_LAST,
    OP_DN_LOAD,
    OP_DN_RD,
    OP_DN_CMP,
    OP_HEAD_RD,
    OP_PUBLISH
  } dp_op_t;

  typedef struct packed {
    logic cmd_remove;
    logic full;
    logic empty;
    logic last_one;
    logic pos_root;
    logic has_child;
    logic out_free;
  } hmq_status_t;

  typedef struct packed {
    dp_op_t op;
  } hmq_cmd_t;

endpackage

>>> hdl/hmq_req_if.sv
interface hmq_req_if import hmq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [FIELD_W-1:0] item_key;
  logic [FIELD_W-1:0] item_payload;

  modport source (output valid, cmd, item_key, item_payload, input ready);
  modport sink   (input valid, cmd, item_key, item_payload, output ready);
endinterface

>>> hdl/hmq_rsp_if.sv
interface hmq_rsp_if import hmq_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [FIELD_W-1:0]     head_key;
  logic [FIELD_W-1:0]     head_payload;
  logic [COUNT_OUT_W-1:0] entry_count;
  logic                   queue_empty;
  logic [STATUS_W-1:0]    status;

  modport source (output valid, head_key, head_payload, entry_count, queue_empty, status,
                  input ready);
  modport sink   (input valid, head_key, head_payload, entry_count, queue_empty, status,
                  output ready);
endinterface

>>> hdl/hmq_ctrl.sv
module hmq_ctrl import hmq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  hmq_status_t st,
  output hmq_cmd_t    cmd
);

  hmq_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          priority if (st.cmd_remove && (st.empty || st.last_one)) state_next = S_HEAD_RD;
          else if (st.cmd_remove)                                 state_next = S_DN_LAST;
          else if (st.full)                                       state_next = S_HEAD_RD;
          else                                                    state_next = S_UP_RD;
        end
      end
      S_UP_RD:   state_next = st.pos_root ? S_HEAD_RD : S_UP_CMP;
      // The datapath loops back only when the parent moved down.
      S_UP_CMP:  state_next = st.pos_root ? S_HEAD_RD : S_UP_RD;
      S_DN_LAST: state_next = S_DN_LOAD;
      S_DN_LOAD: state_next = S_DN_RD;
      S_DN_RD:   state_next = st.has_child ? S_DN_CMP : S_HEAD_RD;
      S_DN_CMP:  state_next = st.has_child ? S_HEAD_RD : S_DN_RD;
      S_HEAD_RD: state_next = S_PUBLISH;
      S_PUBLISH: state_next = st.out_free ? S_IDLE : S_PUBLISH;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    cmd.op    = OP_NONE;
    unique case (state)
      S_IDLE: begin
        // No request is taken while reset is held.
        req_ready = !rst;
        if (req_valid && !rst) cmd.op = OP_ACCEPT;
      end
      S_UP_RD:   cmd.op = OP_UP_RD;
      S_UP_CMP:  cmd.op = OP_UP_CMP;
      S_DN_LAST: cmd.op = OP_DN_LAST;
      S_DN_LOAD: cmd.op = OP_DN_LOAD;
      S_DN_RD:   cmd.op = OP_DN_RD;
      S_DN_CMP:  cmd.op = OP_DN_CMP;
      S_HEAD_RD: cmd.op = OP_HEAD_RD;
      S_PUBLISH: cmd.op = OP_PUBLISH;
      default:   cmd.op = OP_NONE;
    endcase
  end

endmodule

>>> hdl/hmq_datapath.sv
module hmq_datapath import hmq_pkg::*; #(
  parameter int CAPACITY     = DEF_CAPACITY,
  parameter int KEY_BITS     = DEF_KEY_BITS,
  parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  hmq_cmd_t               cmd,
  input  logic                   in_cmd,
  input  logic [FIELD_W-1:0]     in_key,
  input  logic [FIELD_W-1:0]     in_payload,
  output hmq_status_t            st,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [FIELD_W-1:0]     out_key,
  output logic [FIELD_W-1:0]     out_payload,
  output logic [COUNT_OUT_W-1:0] out_count,
  output logic                   out_empty,
  output logic [STATUS_W-1:0]    out_status
);

  localparam int ADDR_W  = $clog2(CAPACITY);
  localparam int COUNT_W = $clog2(CAPACITY + 1);
  localparam int EXT_W   = ADDR_W + 1;
  localparam int ENTRY_W = KEY_BITS + PAYLOAD_BITS;

  logic [ENTRY_W-1:0] mem [CAPACITY];

  logic [COUNT_W-1:0] count;
  logic [ENTRY_W-1:0] mov;
  logic [ADDR_W-1:0]  pos;
  result_status_t     status_r;
  logic [ENTRY_W-1:0] rd_a, rd_b;

  logic               ra_en, rb_en, we;
  logic [ADDR_W-1:0]  ra_addr, rb_addr, wa;
  logic [ENTRY_W-1:0] wd;

  logic [EXT_W-1:0]    count_ext, c1_w, c2_w;
  logic [ADDR_W-1:0]   parent, pick_addr;
  logic                c2_valid, pick_b, up_swap, dn_swap;
  logic [KEY_BITS-1:0] key_mov, key_a, key_b, key_pick;
  logic [ENTRY_W-1:0]  pick_entry;

  assign count_ext = EXT_W'(count);
  assign c1_w      = {pos, 1'b1};
  assign c2_w      = c1_w + EXT_W'(1);
  assign parent    = (pos - ADDR_W'(1)) >> 1;
  assign c2_valid  = c2_w < count_ext;

  assign key_mov = mov[ENTRY_W-1 -: KEY_BITS];
  assign key_a   = rd_a[ENTRY_W-1 -: KEY_BITS];
  assign key_b   = rd_b[ENTRY_W-1 -: KEY_BITS];

  assign pick_b     = c2_valid && (key_b < key_a);
  assign pick_entry = pick_b ? rd_b : rd_a;
  assign pick_addr  = pick_b ? c2_w[ADDR_W-1:0] : c1_w[ADDR_W-1:0];
  assign key_pick   = pick_entry[ENTRY_W-1 -: KEY_BITS];
  assign up_swap    = key_mov < key_a;
  assign dn_swap    = key_pick < key_mov;

  always_comb begin
    st.cmd_remove = (in_cmd == CMD_REMOVE);
    st.full       = (count == COUNT_W'(CAPACITY));
    st.empty      = (count == '0);
    st.last_one   = (count == COUNT_W'(1));
    st.pos_root   = (pos == '0);
    st.has_child  = c1_w < count_ext;
    st.out_free   = !out_valid || out_ready;
    // In the compare states the same flags tell the controller that the walk ends.
    if (cmd.op == OP_UP_CMP) st.pos_root  = !up_swap;
    if (cmd.op == OP_DN_CMP) st.has_child = !dn_swap;
  end

  always_comb begin
    ra_en   = 1'b0;
    rb_en   = 1'b0;
    we      = 1'b0;
    ra_addr = '0;
    rb_addr = '0;
    wa      = pos;
    wd      = mov;
    unique case (cmd.op)
      OP_UP_RD: begin
        if (pos == '0) begin
          we = 1'b1;
        end else begin
          ra_en   = 1'b1;
          ra_addr = parent;
        end
      end
      OP_UP_CMP: begin
        we = 1'b1;
        if (up_swap) wd = rd_a;
      end
      OP_DN_LAST: begin
        ra_en   = 1'b1;
        ra_addr = count[ADDR_W-1:0];
      end
      OP_DN_RD: begin
        if (c1_w < count_ext) begin
          ra_en   = 1'b1;
          rb_en   = 1'b1;
          ra_addr = c1_w[ADDR_W-1:0];
          rb_addr = c2_w[ADDR_W-1:0];
        end else begin
          we = 1'b1;
        end
      end
      OP_DN_CMP: begin
        we = 1'b1;
        if (dn_swap) wd = pick_entry;
      end
      OP_HEAD_RD: begin
        ra_en = 1'b1;
      end
      OP_NONE, OP_ACCEPT, OP_DN_LOAD, OP_PUBLISH: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (ra_en) rd_a <= mem[ra_addr];
    if (rb_en) rd_b <= mem[rb_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == OP_ACCEPT) begin
        if (in_cmd == CMD_REMOVE) begin
          if (count != '0) count <= count - COUNT_W'(1);
        end else if (count != COUNT_W'(CAPACITY)) begin
          count <= count + COUNT_W'(1);
        end
      end
      if (cmd.op == OP_PUBLISH && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_ACCEPT: begin
        status_r <= ST_DONE;
        if (in_cmd == CMD_REMOVE) begin
          if (count == '0) status_r <= ST_EMPTY;
        end else if (count == COUNT_W'(CAPACITY)) begin
          status_r <= ST_FULL;
        end else begin
          mov <= {in_key[KEY_BITS-1:0], in_payload[PAYLOAD_BITS-1:0]};
          pos <= count[ADDR_W-1:0];
        end
      end
      OP_UP_CMP: begin
        if (up_swap) pos <= parent;
      end
      OP_DN_LOAD: begin
        mov <= rd_a;
        pos <= '0;
      end
      OP_DN_CMP: begin
        if (dn_swap) pos <= pick_addr;
      end
      OP_PUBLISH: begin
        if (!out_valid || out_ready) begin
          out_count  <= COUNT_OUT_W'(count);
          out_status <= status_r;
          if (count == '0) begin
            out_key     <= '0;
            out_payload <= '0;
            out_empty   <= 1'b1;
          end else begin
            out_key     <= FIELD_W'(rd_a[ENTRY_W-1 -: KEY_BITS]);
            out_payload <= FIELD_W'(rd_a[PAYLOAD_BITS-1:0]);
            out_empty   <= 1'b0;
          end
        end
      end
      OP_NONE, OP_UP_RD, OP_DN_LAST, OP_DN_RD, OP_HEAD_RD: ;
      default: ;
    endcase
  end

endmodule

>>> hdl/binary_min_heap_queue_unit.sv
// Channel  Direction  Transaction
// req      in         cmd (insert or remove-min), item_key, item_payload
// rsp      out        head_key, head_payload, entry_count, queue_empty, status
//
// One request is worked at a time; each heap level costs a read step and a
// compare and write-back step, after the accept step. Synchronous active-high
// reset empties the queue and holds req not ready; the memory is not cleared,
// since data in slots at or above the fill count is never used.
// A result register frees the block for the next request; a stalled rsp
// holds the following result in its publish step until the earlier one is
// taken.
module binary_min_heap_queue_unit import hmq_pkg::*; #(
  parameter int CAPACITY     = DEF_CAPACITY,
  parameter int KEY_BITS     = DEF_KEY_BITS,
  parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
  input logic       clk,
  input logic       rst,
  hmq_req_if.sink   req,
  hmq_rsp_if.source rsp
);

  // Command from the sequencer and the datapath flags it steers by.
  hmq_cmd_t    cmd;
  hmq_status_t st;

  // The controller owns the request handshake and walks the sift loops.
  hmq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .st        (st),
    .cmd       (cmd)
  );

  // The datapath holds the heap memory, fill count, moving entry and the
  // result register that drives the rsp channel.
  hmq_datapath #(
    .CAPACITY     (CAPACITY),
    .KEY_BITS     (KEY_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .in_cmd      (req.cmd),
    .in_key      (req.item_key),
    .in_payload  (req.item_payload),
    .st          (st),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .out_key     (rsp.head_key),
    .out_payload (rsp.head_payload),
    .out_count   (rsp.entry_count),
    .out_empty   (rsp.queue_empty),
    .out_status  (rsp.status)
  );

endmodule

>>> hdl/hmq_checker.sv
`include "assert_macros.svh"

module hmq_checker import hmq_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   req_valid,
  input logic                   req_ready,
  input logic                   rsp_valid,
  input logic                   rsp_ready,
  input logic [FIELD_W-1:0]     head_key,
  input logic [FIELD_W-1:0]     head_payload,
  input logic [COUNT_OUT_W-1:0] entry_count,
  input logic                   queue_empty,
  input logic [STATUS_W-1:0]    status
);

  localparam int VIEW_W = 2 * FIELD_W + COUNT_OUT_W + 1 + STATUS_W;

  // Requests taken whose results have not yet been taken.
  logic [1:0] outstanding;

  // A result that waits on a stalled sink, the whole result it shows, and
  // whether the head and count all read zero.
  logic              rsp_stall;
  logic [VIEW_W-1:0] rsp_view;
  logic              head_zero;

  assign rsp_stall = rsp_valid && !rsp_ready;
  assign rsp_view  = {head_key, head_payload, entry_count, queue_empty, status};
  assign head_zero = (head_key == '0) && (head_payload == '0) && (entry_count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      unique case ({req_valid && req_ready, rsp_valid && rsp_ready})
        2'b10:   outstanding <= outstanding + 2'd1;
        2'b01:   outstanding <= outstanding - 2'd1;
        default: outstanding <= outstanding;
      endcase
    end
  end

  `HMQ_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_stall, rsp_valid && $stable(rsp_view))
  `HMQ_ASSERT_IMPL(a_rsp_has_req, clk, rst, rsp_valid, outstanding != 2'd0)
  `HMQ_ASSERT_IMPL(a_empty_zero, clk, rst, rsp_valid && queue_empty, head_zero)
  `HMQ_ASSERT_IMPL(a_refused_empty, clk, rst, rsp_valid && status == ST_EMPTY, queue_empty)

endmodule

bind binary_min_heap_queue_unit hmq_checker u_hmq_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .head_key     (rsp.head_key),
  .head_payload (rsp.head_payload),
  .entry_count  (rsp.entry_count),
  .queue_empty  (rsp.queue_empty),
  .status       (rsp.status)
);

>>> dv/tb.sv
module tb;
  import hmq_pkg::*;

  // The heap depth and widths follow the package defaults that the block is
  // built with, so the shadow heap below matches the hardware one slot for slot.
  localparam int CAP        = DEF_CAPACITY;
  localparam int CLK_HALF   = 4;
  localparam int RST_CYCLES = 6;
  // A remove walks up to clog2(CAP) levels, each a read and a compare step,
  // plus fixed steps; the settle time at the end covers that with room to spare.
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_REPORTS   = 20;

  // One result as the block should present it on rsp.
  typedef struct {
    logic [FIELD_W-1:0]     key;
    logic [FIELD_W-1:0]     payload;
    logic [COUNT_OUT_W-1:0] count;
    logic                   empty;
    result_status_t         status;
  } head_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  hmq_req_if req_ch ();
  hmq_rsp_if rsp_ch ();

  binary_min_heap_queue_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source)
  );

  // Shadow copy of the heap. It is advanced at the very edge at which a
  // request transaction is accepted, so it always reflects the order in which
  // the block itself sees the requests.
  logic [FIELD_W-1:0] shadow_key [CAP];
  logic [FIELD_W-1:0] shadow_pay [CAP];
  int unsigned        shadow_fill = 0;

  // Head reports that have been predicted but not yet seen on rsp, oldest first.
  head_report_t head_reports[$];

  int unsigned sent_count    = 0;
  int unsigned checked_count = 0;
  int unsigned full_refusals = 0;
  int unsigned empty_refusals = 0;
  int unsigned error_count   = 0;

  // Sender pacing: a burst counter, and a switch that turns idle gaps off for
  // stretches of back-to-back traffic.
  int unsigned burst_left = 0;
  bit          sender_gaps = 1'b1;

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // A watchdog bounds the run in case the block hangs on a handshake.
  initial begin
    #4_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic [FIELD_W-1:0] tk;
    logic [FIELD_W-1:0] tp;
    tk = shadow_key[a];
    tp = shadow_pay[a];
    shadow_key[a] = shadow_key[b];
    shadow_pay[a] = shadow_pay[b];
    shadow_key[b] = tk;
    shadow_pay[b] = tp;
  endfunction

  // Apply one request to the shadow heap and return the head view that the
  // block must report for it. Comparisons are strict everywhere, so equal keys
  // never trade places, and on the way down the second child wins only when it
  // is strictly smaller than the first.
  function automatic head_report_t apply_heap_op(logic cmd, logic [FIELD_W-1:0] key,
                                                 logic [FIELD_W-1:0] pay);
    head_report_t r;
    int unsigned  pos;
    int unsigned  parent;
    int unsigned  c1;
    int unsigned  c2;
    int unsigned  pick;
    bit           moving;
    r.status = ST_DONE;
    if (cmd == CMD_INSERT) begin
      if (shadow_fill >= CAP) begin
        r.status = ST_FULL;
      end else begin
        pos = shadow_fill;
        shadow_key[pos] = key;
        shadow_pay[pos] = pay;
        shadow_fill++;
        moving = 1'b1;
        while (moving && pos > 0) begin
          parent = (pos - 1) / 2;
          if (shadow_key[pos] < shadow_key[parent]) begin
            swap_slots(pos, parent);
            pos = parent;
          end else begin
            moving = 1'b0;
          end
        end
      end
    end else begin
      if (shadow_fill == 0) begin
        r.status = ST_EMPTY;
      end else begin
        shadow_fill--;
        if (shadow_fill > 0) begin
          shadow_key[0] = shadow_key[shadow_fill];
          shadow_pay[0] = shadow_pay[shadow_fill];
          pos = 0;
          moving = 1'b1;
          while (moving) begin
            c1 = 2 * pos + 1;
            c2 = 2 * pos + 2;
            if (c1 >= shadow_fill) begin
              moving = 1'b0;
            end else begin
              pick = c1;
              if (c2 < shadow_fill && shadow_key[c2] < shadow_key[c1]) pick = c2;
              if (shadow_key[pick] < shadow_key[pos]) begin
                swap_slots(pos, pick);
                pos = pick;
              end else begin
                moving = 1'b0;
              end
            end
          end
        end
      end
    end
    // An empty queue reports a zero head; slots are never read past the fill.
    if (shadow_fill > 0) begin
      r.key     = shadow_key[0];
      r.payload = shadow_pay[0];
      r.empty   = 1'b0;
    end else begin
      r.key     = '0;
      r.payload = '0;
      r.empty   = 1'b1;
    end
    r.count = shadow_fill[COUNT_OUT_W-1:0];
    return r;
  endfunction

  // Key mix: full-range values, a tiny range that forces many ties, values
  // hugging both ends of the range, and a cluster around the top bit.
  function automatic logic [FIELD_W-1:0] pick_key();
    logic [FIELD_W-1:0] k;
    case ($urandom_range(0, 3))
      0: k = $urandom;
      1: k = $urandom_range(0, 7);
      2: k = ($urandom_range(0, 1) ? 32'hFFFF_FFF0 : 32'h0000_0000) | $urandom_range(0, 15);
      default: k = 32'h8000_0000 + $urandom_range(0, 3) - 2;
    endcase
    return k;
  endfunction

  // Send one request transaction. Between bursts the sender may drop valid for
  // a random number of cycles; within a burst valid stays high from one
  // transaction to the next. The prediction is taken at the accepting edge.
  task automatic send_op(input logic cmd, input logic [FIELD_W-1:0] key,
                         input logic [FIELD_W-1:0] pay);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = sender_gaps ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
        @(negedge clk);
        req_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk);
    req_ch.valid        <= 1'b1;
    req_ch.cmd          <= cmd;
    req_ch.item_key     <= key;
    req_ch.item_payload <= pay;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    head_reports.push_back(apply_heap_op(cmd, key, pay));
    burst_left--;
    sent_count++;
  endtask

  // Hold the request side idle until every predicted result has been taken.
  task automatic wait_for_drain();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    burst_left = 0;
    while (head_reports.size() != 0) @(posedge clk);
  endtask

  // Boundary values and the documented corner cases: removing from an empty
  // queue, keys and payloads at both extremes, and runs of equal keys whose
  // order must follow the strict comparisons exactly.
  task automatic test_directed();
    send_op(CMD_REMOVE, 32'h0000_0000, 32'h0000_0000);
    send_op(CMD_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_op(CMD_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_op(CMD_INSERT, 32'h0000_0000, 32'h1234_5678);
    send_op(CMD_INSERT, 32'h8000_0000, 32'hA5A5_A5A5);
    send_op(CMD_INSERT, 32'h0000_0007, 32'h0000_0001);
    send_op(CMD_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(CMD_REMOVE, 32'h5A5A_5A5A, 32'h0F0F_0F0F);
    send_op(CMD_REMOVE, 32'h0000_0000, 32'h0000_0000);
    send_op(CMD_REMOVE, 32'h0000_0000, 32'h0000_0000);
    send_op(CMD_REMOVE, 32'h0000_0000, 32'h0000_0000);
    send_op(CMD_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 1; i <= 5; i++) send_op(CMD_INSERT, 32'h0000_0005, i);
    send_op(CMD_REMOVE, 32'h0000_0000, 32'h0000_0000);
    send_op(CMD_REMOVE, 32'h0000_0000, 32'h0000_0000);
    send_op(CMD_INSERT, 32'h0000_0005, 32'hFFFF_FFFF);
    send_op(CMD_INSERT, 32'h0000_0004, 32'h0000_0000);
    send_op(CMD_REMOVE, 32'h0000_0000, 32'h0000_0000);
    wait_for_drain();
  endtask

  // Fill the queue past its capacity so that inserts are refused, then empty
  // it past zero so that removes are refused. Small keys give many ties.
  task automatic test_fill_drain(input bit tie_keys);
    for (int i = 0; i < CAP + 4; i++) begin
      send_op(CMD_INSERT, tie_keys ? 32'($urandom_range(0, 3)) : $urandom, $urandom);
    end
    for (int i = 0; i < CAP + 4; i++) send_op(CMD_REMOVE, $urandom, $urandom);
  endtask

  // Random traffic whose insert share sets how deep the heap tends to sit.
  task automatic test_random_mix(input int unsigned count, input int unsigned insert_pct);
    logic cmd;
    for (int unsigned i = 0; i < count; i++) begin
      cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
      send_op(cmd, pick_key(), $urandom);
    end
  endtask

  // The response side stalls on a pattern of its own: it changes mode between
  // always ready, coin-flip ready, and mostly ready with occasional long stalls.
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned stall_left;
    mode = 0;
    mode_left = 0;
    stall_left = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(40, 300);
      end
      mode_left--;
      case (mode)
        0: rsp_ch.ready <= 1'b1;
        1: rsp_ch.ready <= 1'($urandom_range(0, 1));
        default: begin
          if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
          end else begin
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 12);
          end
        end
      endcase
    end
  end

  // Every result transaction is compared with the oldest prediction. Inputs
  // move only at the falling edge, so the values seen here are stable.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin : check_head
      head_report_t want;
      if (head_reports.size() == 0) begin
        error_count++;
        $display("%0t: result with no request waiting: key=%h payload=%h count=%0d",
                 $time, rsp_ch.head_key, rsp_ch.head_payload, rsp_ch.entry_count);
      end else begin
        want = head_reports.pop_front();
        checked_count++;
        if (want.status == ST_FULL) full_refusals++;
        if (want.status == ST_EMPTY) empty_refusals++;
        if (rsp_ch.head_key !== want.key || rsp_ch.head_payload !== want.payload ||
            rsp_ch.entry_count !== want.count || rsp_ch.queue_empty !== want.empty ||
            rsp_ch.status !== want.status) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("%0t: mismatch expected key=%h payload=%h count=%0d empty=%b status=%0d",
                     $time, want.key, want.payload, want.count, want.empty, want.status);
            $display("%0t:          actual   key=%h payload=%h count=%0d empty=%b status=%0d",
                     $time, rsp_ch.head_key, rsp_ch.head_payload, rsp_ch.entry_count,
                     rsp_ch.queue_empty, rsp_ch.status);
          end
        end
      end
    end
  end

  initial begin
    int unsigned settle;
    req_ch.valid        = 1'b0;
    req_ch.cmd          = CMD_INSERT;
    req_ch.item_key     = '0;
    req_ch.item_payload = '0;
    rst = 1'b1;
    repeat (RST_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_fill_drain(1'b0);
    test_random_mix(370, 65);
    // Back-to-back traffic with no sender gaps, then a full pause.
    sender_gaps = 1'b0;
    test_fill_drain(1'b1);
    sender_gaps = 1'b1;
    wait_for_drain();
    test_random_mix(370, 50);
    test_fill_drain(1'b0);
    test_random_mix(370, 35);

    // Wait for the last results, then give the block time to show anything
    // spurious before judging the run.
    wait_for_drain();
    settle = 0;
    while (settle < SETTLE_CYCLES) begin
      @(posedge clk);
      settle++;
    end
    if (head_reports.size() != 0) error_count++;

    $display("Sent %0d requests and checked %0d head reports.", sent_count, checked_count);
    $display("Refused inserts on a full queue: %0d, refused removes on an empty queue: %0d.",
             full_refusals, empty_refusals);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
